@@ rtl/core/sktn_pkg.sv @@
package sktn_pkg;

    // Fixed field widths of the item and result formats.
    localparam int MAX_SLOTS     = 8;
    localparam int JOINT_BITS    = 10;
    localparam int WEIGHT_BITS   = 17;
    localparam int FRAC_BITS     = 16;
    localparam int SLOT_NUM_BITS = 3;
    localparam int CFG_BITS      = 4;
    localparam int COUNT_BITS    = 16;

    // Derived widths.
    localparam int SLOT_BITS     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SLOT_CNT_BITS = $clog2(MAX_SLOTS + 1);
    localparam int SUM_BITS      = WEIGHT_BITS + SLOT_BITS;
    localparam int NUM_BITS      = WEIGHT_BITS + FRAC_BITS;
    localparam int QUO_BITS      = WEIGHT_BITS;
    localparam int STEP_BITS     = $clog2(QUO_BITS + 1);

    localparam logic [WEIGHT_BITS-1:0] ONE_Q16   = WEIGHT_BITS'(65536);
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX = '1;
    localparam logic [CFG_BITS-1:0]    CFG_RESET = CFG_BITS'(4);

    typedef struct packed {
        logic                   has_influence;
        logic [JOINT_BITS-1:0]  joint_index;
        logic [WEIGHT_BITS-1:0] influence_weight;
        logic                   vertex_end;
    } item_t;

    typedef struct packed {
        logic [SLOT_NUM_BITS-1:0] slot_number;
        logic [JOINT_BITS-1:0]    out_joint;
        logic [WEIGHT_BITS-1:0]   out_weight;
        logic                     last_slot;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 insert;
        logic                 sum_clear;
        logic                 sum_acc;
        logic                 div_load;
        logic                 emit;
        logic                 emit_norm;
        logic                 clear;
        logic [SLOT_BITS-1:0] slot;
        logic                 last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic                  div_done;
    } status_t;

endpackage

@@ rtl/core/skin_weight_topk_normalizer.sv @@
// An influence without vertex end is absorbed in the accept cycle, so such
// requests go at one per cycle. A vertex end keeps busy high until its m slots
// are emitted and the list is cleared (m = slot count), also when normalizing.
// Each normalized slot costs one pass of the shared restoring divider.
// Results cannot be stalled: each slot shows on the result port for one cycle.
// Reset (rst_n low, asynchronous) empties the list and sets the slot count to 4.

module skin_weight_topk_normalizer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sktn_pkg::item_t               item,
    output logic                          strobe,
    output sktn_pkg::result_t             result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sktn_pkg::CFG_BITS-1:0] cfg_data
);

    // The controller sequences one vertex at a time. While it is idle every
    // request is taken at once and its influence is placed into the sorted
    // list in that same cycle. A request that ends a vertex starts the
    // emission: the controller first decides whether the kept weights need
    // normalizing, then either walks the slots one per cycle or sums the
    // weights and, for each slot, loads the divider and waits for its quotient.
    sktn_pkg::cmd_t    cmd;
    sktn_pkg::status_t status;

    // The slot count register can always take a write; the user must write it
    // only between vertices, and the block itself does not enforce that.
    assign cfg_ready = 1'b1;

    sktn_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .has_influence (item.has_influence),
        .vertex_end    (item.vertex_end),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .status        (status),
        .cmd           (cmd),
        .busy          (busy)
    );

    // The datapath holds the sorted list, the saturating influence counter,
    // the weight sum, the divider and the result register.
    sktn_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result),
        .strobe (strobe)
    );

endmodule

@@ rtl/core/sktn_div.sv @@
module sktn_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic [sktn_pkg::NUM_BITS-1:0]     numerator,
    input  logic [sktn_pkg::SUM_BITS-1:0]     divisor,
    output logic [sktn_pkg::QUO_BITS-1:0]     quotient,
    output logic                              done
);

    // Restoring division, one quotient bit per cycle. The quotient is known
    // to fit QUO_BITS, so the upper numerator bits start as the remainder.
    logic [sktn_pkg::SUM_BITS-1:0]  rem_reg, rem_next;
    logic [sktn_pkg::QUO_BITS-1:0]  low_reg, low_next;
    logic [sktn_pkg::STEP_BITS-1:0] step_reg, step_next;
    logic                           run_reg, run_next;
    logic                           done_reg, done_next;
    logic [sktn_pkg::SUM_BITS:0]    trial;
    logic                           fits;

    always_comb
    begin
        trial     = {rem_reg, low_reg[sktn_pkg::QUO_BITS-1]};
        fits      = trial >= {1'b0, divisor};
        rem_next  = rem_reg;
        low_next  = low_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (load)
        begin
            rem_next  = sktn_pkg::SUM_BITS'(numerator[sktn_pkg::NUM_BITS-1:sktn_pkg::QUO_BITS]);
            low_next  = numerator[sktn_pkg::QUO_BITS-1:0];
            step_next = sktn_pkg::STEP_BITS'(sktn_pkg::QUO_BITS);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next  = fits ? sktn_pkg::SUM_BITS'(trial - {1'b0, divisor})
                             : trial[sktn_pkg::SUM_BITS-1:0];
            low_next  = {low_reg[sktn_pkg::QUO_BITS-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == sktn_pkg::STEP_BITS'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

    assign quotient = low_reg;
    assign done     = done_reg;

endmodule

@@ rtl/core/sktn_datapath.sv @@
module sktn_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  sktn_pkg::item_t   item,
    input  sktn_pkg::cmd_t    cmd,
    output sktn_pkg::status_t status,
    output sktn_pkg::result_t result,
    output logic              strobe
);

    logic [sktn_pkg::JOINT_BITS-1:0]    joint_reg  [sktn_pkg::MAX_SLOTS];
    logic [sktn_pkg::JOINT_BITS-1:0]    joint_next [sktn_pkg::MAX_SLOTS];
    logic [sktn_pkg::WEIGHT_BITS-1:0]   weight_reg  [sktn_pkg::MAX_SLOTS];
    logic [sktn_pkg::WEIGHT_BITS-1:0]   weight_next [sktn_pkg::MAX_SLOTS];
    logic [sktn_pkg::COUNT_BITS-1:0]    count_reg, count_next;
    logic [sktn_pkg::SUM_BITS-1:0]      sum_reg, sum_next;
    sktn_pkg::result_t                  result_reg, result_next;
    logic                               strobe_reg;

    logic [sktn_pkg::WEIGHT_BITS-1:0]   w_in;
    logic [sktn_pkg::SLOT_CNT_BITS-1:0] kept;
    logic [sktn_pkg::MAX_SLOTS-1:0]     tail;
    logic [sktn_pkg::JOINT_BITS-1:0]    rd_joint;
    logic [sktn_pkg::WEIGHT_BITS-1:0]   rd_weight;
    logic [sktn_pkg::NUM_BITS-1:0]      numerator;
    logic [sktn_pkg::QUO_BITS-1:0]      quotient;
    logic [sktn_pkg::WEIGHT_BITS-1:0]   norm_weight;
    logic                               div_done;

    assign w_in = (item.influence_weight > sktn_pkg::ONE_Q16) ? sktn_pkg::ONE_Q16
                                                              : item.influence_weight;
    assign kept = (count_reg >= sktn_pkg::COUNT_BITS'(sktn_pkg::MAX_SLOTS))
                  ? sktn_pkg::SLOT_CNT_BITS'(sktn_pkg::MAX_SLOTS)
                  : sktn_pkg::SLOT_CNT_BITS'(count_reg);

    // Every slot from the insertion point on moves back by one. The new entry
    // goes ahead of the first kept weight that is strictly smaller, or at the
    // end of the kept entries if there is room.
    always_comb
    begin
        logic acc;
        acc = 1'b0;
        for (int i = 0; i < sktn_pkg::MAX_SLOTS; i++)
        begin
            acc = acc
                | ((sktn_pkg::SLOT_CNT_BITS'(i) < kept) && (w_in > weight_reg[i]))
                | (sktn_pkg::SLOT_CNT_BITS'(i) >= kept);
            tail[i] = acc;
        end
    end

    always_comb
    begin
        for (int i = 0; i < sktn_pkg::MAX_SLOTS; i++)
        begin
            joint_next[i]  = joint_reg[i];
            weight_next[i] = weight_reg[i];
            if (cmd.clear)
            begin
                joint_next[i]  = '0;
                weight_next[i] = '0;
            end
            else if (cmd.insert && tail[i])
            begin
                if (i == 0)
                begin
                    joint_next[i]  = item.joint_index;
                    weight_next[i] = w_in;
                end
                else if (!tail[(i > 0) ? i - 1 : 0])
                begin
                    joint_next[i]  = item.joint_index;
                    weight_next[i] = w_in;
                end
                else
                begin
                    joint_next[i]  = joint_reg[(i > 0) ? i - 1 : 0];
                    weight_next[i] = weight_reg[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
            count_next = '0;
        else if (cmd.insert && (count_reg != sktn_pkg::COUNT_MAX))
            count_next = count_reg + 1'b1;
    end

    assign rd_joint  = joint_reg[cmd.slot];
    assign rd_weight = weight_reg[cmd.slot];

    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.sum_clear)
            sum_next = '0;
        else if (cmd.sum_acc)
            sum_next = sum_reg + sktn_pkg::SUM_BITS'(rd_weight);
    end

    // Rounded quotient: (w * 1.0 + sum / 2) / sum.
    assign numerator = {rd_weight, {sktn_pkg::FRAC_BITS{1'b0}}}
                     + sktn_pkg::NUM_BITS'(sum_reg >> 1);

    sktn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (cmd.div_load),
        .numerator (numerator),
        .divisor   (sum_reg),
        .quotient  (quotient),
        .done      (div_done)
    );

    always_comb
    begin
        if (sum_reg == '0)
            norm_weight = '0;
        else if (quotient > sktn_pkg::ONE_Q16)
            norm_weight = sktn_pkg::ONE_Q16;
        else
            norm_weight = quotient;
        result_next             = result_reg;
        result_next.slot_number = sktn_pkg::SLOT_NUM_BITS'(cmd.slot);
        result_next.out_joint   = rd_joint;
        result_next.out_weight  = cmd.emit_norm ? norm_weight : rd_weight;
        result_next.last_slot   = cmd.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sktn_pkg::MAX_SLOTS; i++)
            begin
                joint_reg[i]  <= '0;
                weight_reg[i] <= '0;
            end
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < sktn_pkg::MAX_SLOTS; i++)
            begin
                joint_reg[i]  <= joint_next[i];
                weight_reg[i] <= weight_next[i];
            end
            count_reg  <= count_next;
            strobe_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (cmd.emit)
            result_reg <= result_next;
    end

    assign status.count    = count_reg;
    assign status.div_done = div_done;
    assign result          = result_reg;
    assign strobe          = strobe_reg;

endmodule

@@ rtl/core/sktn_ctrl.sv @@
module sktn_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          has_influence,
    input  logic                          vertex_end,
    input  logic                          cfg_write,
    input  logic [sktn_pkg::CFG_BITS-1:0] cfg_data,
    input  sktn_pkg::status_t             status,
    output sktn_pkg::cmd_t                cmd,
    output logic                          busy
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SUM,
        ST_DIV_LOAD,
        ST_DIV_WAIT,
        ST_EMIT,
        ST_CLEAR
    } state_t;

    state_t                               state_reg, state_next;
    logic [sktn_pkg::SLOT_BITS-1:0]       slot_reg, slot_next;
    logic                                 norm_reg, norm_next;
    logic                                 busy_reg, busy_next;
    logic [sktn_pkg::CFG_BITS-1:0]        cfg_reg, cfg_next;
    logic [sktn_pkg::SLOT_CNT_BITS-1:0]   slots;
    logic [sktn_pkg::SLOT_BITS-1:0]       slot_last;
    logic                                 accept;
    logic                                 at_last;

    // Slot count clamped to 1..MAX_SLOTS.
    always_comb
    begin
        if (cfg_reg == '0)
            slots = sktn_pkg::SLOT_CNT_BITS'(1);
        else if (int'(cfg_reg) > sktn_pkg::MAX_SLOTS)
            slots = sktn_pkg::SLOT_CNT_BITS'(sktn_pkg::MAX_SLOTS);
        else
            slots = sktn_pkg::SLOT_CNT_BITS'(cfg_reg);
    end

    assign slot_last = sktn_pkg::SLOT_BITS'(slots - 1'b1);
    assign at_last   = (slot_reg == slot_last);
    assign accept    = start && !busy_reg;

    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        norm_next     = norm_reg;
        cfg_next      = cfg_write ? cfg_data : cfg_reg;
        cmd           = '0;
        cmd.slot      = slot_reg;
        cmd.last      = at_last;
        cmd.insert    = accept && has_influence;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && vertex_end)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.sum_clear = 1'b1;
                slot_next     = '0;
                norm_next     = status.count > sktn_pkg::COUNT_BITS'(slots);
                state_next    = norm_next ? ST_SUM : ST_EMIT;
            end
            ST_SUM:
            begin
                cmd.sum_acc = 1'b1;
                if (at_last)
                begin
                    slot_next  = '0;
                    state_next = ST_DIV_LOAD;
                end
                else
                    slot_next = slot_reg + 1'b1;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_norm = 1'b1;
                    if (at_last)
                        state_next = ST_CLEAR;
                    else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = ST_DIV_LOAD;
                    end
                end
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (at_last)
                    state_next = ST_CLEAR;
                else
                    slot_next = slot_reg + 1'b1;
            end
            ST_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            norm_reg  <= 1'b0;
            busy_reg  <= 1'b0;
            cfg_reg   <= sktn_pkg::CFG_RESET;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            norm_reg  <= norm_next;
            busy_reg  <= busy_next;
            cfg_reg   <= cfg_next;
        end
    end

    assign busy = busy_reg;

endmodule

@@ rtl/core/sktn_checker.sv @@
module sktn_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input sktn_pkg::item_t   item,
    input logic              strobe,
    input sktn_pkg::result_t result
);

    // Results only appear while a vertex is being emitted.
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result strobe while idle");

    // A request that ends a vertex starts an emission.
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.vertex_end) |=> busy)
        else $error("vertex end did not start an emission");

    // A request that does not end a vertex is absorbed without output.
    a_mid_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !item.vertex_end) |=> (!busy && !strobe))
        else $error("mid-vertex request caused activity");

    // The last slot is followed by a gap before anything else.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last_slot) |=> !strobe)
        else $error("result after the last slot");

endmodule

bind skin_weight_topk_normalizer sktn_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
);

@@ tb/sv/skin_weight_topk_checker.sv @@
`timescale 1ns / 1ps

module skin_weight_topk_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  sktn_pkg::item_t               item,
    input  logic                          strobe,
    input  sktn_pkg::result_t             result,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [sktn_pkg::CFG_BITS-1:0] cfg_data,
    output int unsigned                   mismatches,
    output int unsigned                   slots_pending
);

    localparam int REPORT_LIMIT = 10;

    // Local copy of the block's list, counter and slot count register.
    logic [sktn_pkg::JOINT_BITS-1:0]  kept_joint  [sktn_pkg::MAX_SLOTS];
    logic [sktn_pkg::WEIGHT_BITS-1:0] kept_weight [sktn_pkg::MAX_SLOTS];
    logic [sktn_pkg::COUNT_BITS-1:0]  infl_count;
    logic [sktn_pkg::CFG_BITS-1:0]    slot_cfg;
    sktn_pkg::result_t                expected_slots[$];
    sktn_pkg::result_t                want;
    logic [sktn_pkg::WEIGHT_BITS-1:0] clipped_weight;
    int unsigned                      fail_count;

    task automatic clear_list();
        int i;
        for (i = 0; i < sktn_pkg::MAX_SLOTS; i++)
        begin
            kept_joint[i]  = '0;
            kept_weight[i] = '0;
        end
        infl_count = '0;
    endtask

    // Sorted insertion: a new weight goes ahead of the first strictly smaller one.
    task automatic add_influence(input logic [sktn_pkg::JOINT_BITS-1:0] joint,
                                 input logic [sktn_pkg::WEIGHT_BITS-1:0] weight);
        int kept;
        int pos;
        int top_idx;
        int i;
        kept = (infl_count < sktn_pkg::MAX_SLOTS) ? int'(infl_count) : sktn_pkg::MAX_SLOTS;
        pos  = kept;
        for (i = kept - 1; i >= 0; i--)
            if (weight > kept_weight[i])
                pos = i;
        if (pos < sktn_pkg::MAX_SLOTS)
        begin
            top_idx = (kept < sktn_pkg::MAX_SLOTS) ? kept : sktn_pkg::MAX_SLOTS - 1;
            for (i = top_idx; i > pos; i--)
            begin
                kept_joint[i]  = kept_joint[i - 1];
                kept_weight[i] = kept_weight[i - 1];
            end
            kept_joint[pos]  = joint;
            kept_weight[pos] = weight;
        end
        if (infl_count != sktn_pkg::COUNT_MAX)
            infl_count++;
    endtask

    task automatic emit_slots();
        int                m;
        int                k;
        logic              norm;
        logic [63:0]       total;
        logic [63:0]       w;
        sktn_pkg::result_t slot;
        if (slot_cfg == 0)
            m = 1;
        else if (slot_cfg > sktn_pkg::MAX_SLOTS)
            m = sktn_pkg::MAX_SLOTS;
        else
            m = int'(slot_cfg);
        norm  = infl_count > m;
        total = '0;
        for (k = 0; k < m; k++)
            total += kept_weight[k];
        for (k = 0; k < m; k++)
        begin
            slot.out_joint = (k < infl_count) ? kept_joint[k] : '0;
            w = (k < infl_count) ? 64'(kept_weight[k]) : 64'd0;
            if (norm)
            begin
                if (total == 0)
                    w = '0;
                else
                    w = (w * 64'd65536 + total / 2) / total;
                if (w > sktn_pkg::ONE_Q16)
                    w = sktn_pkg::ONE_Q16;
            end
            slot.slot_number = sktn_pkg::SLOT_NUM_BITS'(k);
            slot.out_weight  = sktn_pkg::WEIGHT_BITS'(w);
            slot.last_slot   = (k + 1 == m);
            expected_slots.push_back(slot);
        end
        clear_list();
    endtask

    // Compares one slot shown by the block with the oldest expected one.
    task automatic check_slot();
        if (expected_slots.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("unexpected slot at %0t: slot %0d joint %0d weight %0d last %0d",
                         $time, result.slot_number, result.out_joint,
                         result.out_weight, result.last_slot);
        end
        else
        begin
            want = expected_slots.pop_front();
            if (result !== want)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                begin
                    $display("mismatch at %0t: expected slot %0d joint %0d weight %0d last %0d",
                             $time, want.slot_number, want.out_joint,
                             want.out_weight, want.last_slot);
                    $display("    got slot %0d joint %0d weight %0d last %0d",
                             result.slot_number, result.out_joint,
                             result.out_weight, result.last_slot);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_list();
            slot_cfg = sktn_pkg::CFG_RESET;
            expected_slots.delete();
            fail_count = 0;
        end
        else
        begin
            // Results first: a slot can never come from a request accepted at this edge.
            if (strobe)
                check_slot();
            if (cfg_valid && cfg_ready)
                slot_cfg = cfg_data;
            if (start && !busy)
            begin
                clipped_weight = (item.influence_weight > sktn_pkg::ONE_Q16)
                                 ? sktn_pkg::ONE_Q16 : item.influence_weight;
                if (item.has_influence)
                    add_influence(item.joint_index, clipped_weight);
                if (item.vertex_end)
                    emit_slots();
            end
        end
        mismatches    <= fail_count;
        slots_pending <= expected_slots.size();
    end

endmodule

@@ tb/sv/skin_weight_topk_normalizer_test.sv @@
`timescale 1ns / 1ps

module skin_weight_topk_normalizer_test;

    // Longest run of cycles without any accepted request, slot or register write.
    localparam int STALL_LIMIT   = 2000;
    // Cycles left to the block after the last slot before the register is touched.
    localparam int SETTLE_CYCLES = 8;
    // Cycles watched after the final slot for anything left over.
    localparam int TAIL_CYCLES   = 40;
    // Useful requests per random phase. Six phases together with the directed
    // requests and the ignored ones in between give about 320 requests.
    localparam int PHASE_REQUESTS = 48;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    sktn_pkg::item_t               item;
    logic                          strobe;
    sktn_pkg::result_t             result;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [sktn_pkg::CFG_BITS-1:0] cfg_data;

    int unsigned mismatches;
    int unsigned slots_pending;
    int unsigned quiet_cycles = 0;
    int unsigned useful_sent  = 0;
    bit          idle_on;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    skin_weight_topk_normalizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .strobe    (strobe),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // The checker follows every handshake on its own and keeps the expected slots.
    skin_weight_topk_checker slot_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .strobe        (strobe),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .slots_pending (slots_pending)
    );

    // Issues one request. It is called right after a rising edge and returns right
    // after the edge that accepted it. Busy is sampled on the falling edge, where it
    // already holds the value that the next rising edge will see, so the hand-off
    // does not depend on the order of events within the edge. When the sender idles,
    // start drops for whole cycles; a request that follows an accepted one directly
    // keeps start high without touching it twice in one step.
    task automatic send_request(input logic has, input int joint, input int weight,
                                input logic last);
        sktn_pkg::item_t req;
        bit              taken;
        req.has_influence    = has;
        req.joint_index      = sktn_pkg::JOINT_BITS'(joint);
        req.influence_weight = sktn_pkg::WEIGHT_BITS'(weight);
        req.vertex_end       = last;
        while (idle_on && $urandom_range(99) < 35)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= req;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        // Requests that carry nothing and end nothing are ignored by the block.
        if (has || last)
            useful_sent++;
    endtask

    // Lets every expected slot come out, then gives the block time to settle so
    // that it is idle before the slot count register is written.
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (slots_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_slot_count(input logic [sktn_pkg::CFG_BITS-1:0] value);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
    endtask

    // One vertex of n influences. Weights mix the full 17-bit range (values above
    // 1.0 get clipped), values up to 1.0, a few coarse levels that force ties, and
    // tiny values. Now and then an ignored request without influence slips in, and
    // some vertices are closed by a separate request that carries no influence.
    task automatic send_vertex(input int n, input bit end_alone);
        int k;
        int w;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(9) == 0)
                send_request(1'b0, $urandom_range(1023), $urandom_range(131071), 1'b0);
            case ($urandom_range(3))
                0:       w = $urandom_range(131071);
                1:       w = $urandom_range(65536);
                2:       w = 16384 * $urandom_range(4);
                default: w = $urandom_range(255);
            endcase
            send_request(1'b1, $urandom_range(1023), w, !end_alone && k == n - 1);
        end
        if (end_alone || n == 0)
            send_request(1'b0, $urandom_range(1023), $urandom_range(131071), 1'b1);
    endtask

    // Whole vertices until the phase has its share of useful requests. Vertex sizes
    // run past eight so that every slot count sees short, exact and overfull vertices.
    task automatic random_phase(input logic [sktn_pkg::CFG_BITS-1:0] slot_count);
        int unsigned target;
        write_slot_count(slot_count);
        target = useful_sent + PHASE_REQUESTS;
        while (useful_sent < target)
            send_vertex($urandom_range(11), $urandom_range(3) == 0);
        drain();
    endtask

    // The watchdog: any accepted request, slot or register write restarts it.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int k;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        idle_on   = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset slot count of four.
        // An empty vertex gives four padding slots.
        send_request(1'b0, 0, 0, 1'b1);
        // One influence with every weight bit set is clipped to 1.0 and padded.
        send_request(1'b1, 1023, 131071, 1'b1);
        // Exactly four influences, three with equal weights: the earlier arrival stays
        // ahead, weights pass unchanged, and an ignored request sits in between.
        send_request(1'b1, 10, 1000, 1'b0);
        send_request(1'b1, 11, 1000, 1'b0);
        send_request(1'b1, 12, 2000, 1'b0);
        send_request(1'b0, 1023, 131071, 1'b0);
        send_request(1'b1, 13, 1000, 1'b1);
        // Six influences with a tie and a zero weight: the top four are normalized,
        // and a request without influence closes the vertex.
        send_request(1'b1, 1, 65536, 1'b0);
        send_request(1'b1, 2, 1, 1'b0);
        send_request(1'b1, 3, 30000, 1'b0);
        send_request(1'b1, 4, 0, 1'b0);
        send_request(1'b1, 5, 65535, 1'b0);
        send_request(1'b1, 6, 30000, 1'b0);
        send_request(1'b0, 0, 0, 1'b1);
        // Five zero weights: the normalizing sum is zero, so every slot weighs zero.
        for (k = 0; k < 5; k++)
            send_request(1'b1, 20 + k, 0, k == 4);
        drain();

        // Random phases over the extremes of the register and some values between.
        // Zero acts as one slot and anything above eight as eight. The phase with
        // eight slots runs without sender gaps.
        random_phase(4'd1);
        idle_on = 1'b0;
        random_phase(4'd8);
        idle_on = 1'b1;
        random_phase(4'd15);
        random_phase(4'd0);
        random_phase(4'd6);
        random_phase(4'd3);

        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && slots_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
